// ===== hdl/e2q_pkg.sv =====
package e2q_pkg;

  localparam int unsigned TrigW = 34;

  localparam logic signed [TrigW-1:0] Q30HalfPi = 34'sh06487ED51;
  localparam logic signed [TrigW-1:0] Q30Pi     = 34'sh0C90FDAA2;
  localparam logic signed [TrigW-1:0] Q30Gain   = 34'sh026DD3B6A;

  typedef logic signed [TrigW-1:0] trig_t;

  typedef struct packed {
    trig_t x;
    trig_t y;
    trig_t z;
    logic  flip;
  } cordic_t;

  function automatic trig_t atan_q30(input logic [4:0] idx);
    trig_t r;
    case (idx)
      5'd0:  r = 34'sh03243F6A8;
      5'd1:  r = 34'sh01DAC6705;
      5'd2:  r = 34'sh00FADBAFC;
      5'd3:  r = 34'sh007F56EA6;
      5'd4:  r = 34'sh003FEAB76;
      5'd5:  r = 34'sh001FFD55B;
      5'd6:  r = 34'sh000FFFAAA;
      5'd7:  r = 34'sh0007FFF55;
      5'd8:  r = 34'sh0003FFFEA;
      5'd9:  r = 34'sh0001FFFFD;
      5'd10: r = 34'sh0000FFFFF;
      5'd11: r = 34'sh00007FFFF;
      5'd12: r = 34'sh00003FFFF;
      5'd13: r = 34'sh00001FFFF;
      5'd14: r = 34'sh00000FFFF;
      5'd15: r = 34'sh000007FFF;
      5'd16: r = 34'sh000003FFF;
      5'd17: r = 34'sh000001FFF;
      5'd18: r = 34'sh000000FFF;
      5'd19: r = 34'sh0000007FF;
      5'd20: r = 34'sh0000003FF;
      5'd21: r = 34'sh0000001FF;
      5'd22: r = 34'sh0000000FF;
      5'd23: r = 34'sh00000007F;
      5'd24: r = 34'sh00000003F;
      5'd25: r = 34'sh00000001F;
      5'd26: r = 34'sh00000000F;
      5'd27: r = 34'sh000000008;
      5'd28: r = 34'sh000000004;
      5'd29: r = 34'sh000000002;
      5'd30: r = 34'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/e2q_if.sv =====
interface e2q_angle_if #(parameter int unsigned ANGLE_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [ANGLE_WIDTH-1:0] roll_angle;
  logic signed [ANGLE_WIDTH-1:0] pitch_angle;
  logic signed [ANGLE_WIDTH-1:0] yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface e2q_quat_if #(parameter int unsigned QUAT_WIDTH = 16);
  logic valid;
  logic ready;
  logic signed [QUAT_WIDTH-1:0] quat_w;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== hdl/e2q_front.sv =====
module e2q_front #(
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic in_valid_i,
  input  logic signed [ANGLE_WIDTH-1:0] roll_i,
  input  logic signed [ANGLE_WIDTH-1:0] pitch_i,
  input  logic signed [ANGLE_WIDTH-1:0] yaw_i,
  output logic out_valid_o,
  output e2q_pkg::trig_t sin_o [3],
  output e2q_pkg::trig_t cos_o [3]
);
  import e2q_pkg::*;

  localparam int unsigned Stages = TRIG_ITERATIONS + 1;

  logic    vld_q [Stages];
  cordic_t st_q  [Stages][3];
  cordic_t st_d  [Stages][3];
  logic signed [ANGLE_WIDTH-1:0] ang [3];

  assign ang[0] = roll_i;
  assign ang[1] = pitch_i;
  assign ang[2] = yaw_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trig_t a;
      a = trig_t'(ang[k]) <<< (32 - ANGLE_WIDTH);
      st_d[0][k].x = Q30Gain;
      st_d[0][k].y = '0;
      st_d[0][k].flip = 1'b0;
      st_d[0][k].z = a;
      if (a > Q30HalfPi) begin
        st_d[0][k].z = Q30Pi - a;
        st_d[0][k].flip = 1'b1;
      end else if (a < -Q30HalfPi) begin
        st_d[0][k].z = -Q30Pi - a;
        st_d[0][k].flip = 1'b1;
      end
    end
    for (int s = 1; s < Stages; s++) begin
      for (int k = 0; k < 3; k++) begin
        cordic_t c;
        trig_t dx;
        trig_t dy;
        trig_t at;
        c  = st_q[s-1][k];
        dx = c.y >>> (s - 1);
        dy = c.x >>> (s - 1);
        at = atan_q30(5'(s - 1));
        st_d[s][k] = c;
        if (!c.z[TrigW-1]) begin
          st_d[s][k].x = c.x - dx;
          st_d[s][k].y = c.y + dy;
          st_d[s][k].z = c.z - at;
        end else begin
          st_d[s][k].x = c.x + dx;
          st_d[s][k].y = c.y - dy;
          st_d[s][k].z = c.z + at;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) vld_q[s] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= in_valid_i;
      for (int s = 1; s < Stages; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int s = 0; s < Stages; s++) st_q[s] <= st_d[s];
    end
  end

  assign out_valid_o = vld_q[Stages-1];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sin_o[k] = st_q[Stages-1][k].y;
      cos_o[k] = st_q[Stages-1][k].flip ? -st_q[Stages-1][k].x : st_q[Stages-1][k].x;
    end
  end
endmodule

// ===== hdl/e2q_queue.sv =====
module e2q_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(DEPTH);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0] wp_q, rp_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (push_i ? 1'b1 : 1'b0) - (pop_i ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign data_o = mem_q[rp_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
endmodule

// ===== hdl/e2q_back.sv =====
module e2q_back #(
  parameter int unsigned QUAT_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic in_valid_i,
  input  e2q_pkg::trig_t sin_i [3],
  input  e2q_pkg::trig_t cos_i [3],
  output logic out_valid_o,
  output logic signed [QUAT_WIDTH-1:0] quat_o [4]
);
  import e2q_pkg::*;

  localparam int unsigned Sh = 60 - (QUAT_WIDTH - 2);
  localparam int unsigned AccW = 66;

  logic [2:0] vld_q;
  trig_t yr_q [8];
  trig_t pf_q [8];
  logic signed [AccW-1:0] t_q [8];
  logic signed [AccW-1:0] t_d [8];
  logic signed [QUAT_WIDTH-1:0] q_q [4];
  trig_t yr_d [8];
  trig_t pf_d [8];
  logic signed [QUAT_WIDTH-1:0] q_d [4];

  // term order: w+, w+, x+, x-, y+, y+, z+, z-
  always_comb begin
    trig_t cr, sr, cp, sp, cy, sy;
    logic signed [2*TrigW-1:0] pr [8];
    cr = cos_i[0]; sr = sin_i[0];
    cp = cos_i[1]; sp = sin_i[1];
    cy = cos_i[2]; sy = sin_i[2];
    pr[0] = cy * cr; pf_d[0] = cp;
    pr[1] = sy * sr; pf_d[1] = sp;
    pr[2] = cy * sr; pf_d[2] = cp;
    pr[3] = sy * cr; pf_d[3] = sp;
    pr[4] = cy * cr; pf_d[4] = sp;
    pr[5] = sy * sr; pf_d[5] = cp;
    pr[6] = sy * cr; pf_d[6] = cp;
    pr[7] = cy * sr; pf_d[7] = sp;
    for (int k = 0; k < 8; k++) yr_d[k] = TrigW'(pr[k] >>> 30);
  end

  always_comb begin
    logic signed [2*TrigW-1:0] tp;
    for (int k = 0; k < 8; k++) begin
      tp = yr_q[k] * pf_q[k];
      t_d[k] = AccW'(tp);
    end
  end

  always_comb begin
    logic signed [AccW-1:0] acc, r, one;
    one = AccW'(1) <<< (QUAT_WIDTH - 2);
    for (int c = 0; c < 4; c++) begin
      acc = (c == 0 || c == 2) ? t_q[2*c] + t_q[2*c+1] : t_q[2*c] - t_q[2*c+1];
      r = (acc + (AccW'(1) <<< (Sh - 1))) >>> Sh;
      if (r > one) r = one;
      if (r < -one) r = -one;
      q_d[c] = QUAT_WIDTH'(r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv_i) vld_q <= {vld_q[1:0], in_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 8; k++) begin
        yr_q[k] <= yr_d[k];
        pf_q[k] <= pf_d[k];
        t_q[k] <= t_d[k];
      end
      for (int c = 0; c < 4; c++) q_q[c] <= q_d[c];
    end
  end

  assign out_valid_o = vld_q[2];
  assign quat_o = q_q;
endmodule

// ===== hdl/euler_to_quaternion_core.sv =====
// Euler angle (Z-Y-X) to unit quaternion converter.
// in_if carries roll, pitch and yaw in signed Q3.(ANGLE_WIDTH-3) radians;
// out_if returns w, x, y, z in signed Q1.(QUAT_WIDTH-2), clamped to +/-1.
// One beat in gives exactly one beat out, in order.
// Throughput: one beat per cycle while out_if.ready stays high.
// From accept to out valid a beat passes the fold register, one CORDIC
// stage per iteration, the middle queue, two product stages, a round
// stage and the output queue.
// The front CORDIC pipe and the back product pipe advance separately; a
// queue between them absorbs back stalls, and the front keeps accepting
// while the queue has room for everything in flight.
// The output queue holds its beat while out_if.ready is low.
// Reset clears all valid flags, queue pointers and queue counts; nothing else is cleared.
module euler_to_quaternion_core #(
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned QUAT_WIDTH = 16,
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  e2q_angle_if.sink in_if,
  e2q_quat_if.source out_if
);
  import e2q_pkg::*;

  localparam int unsigned FrontLat = TRIG_ITERATIONS + 1;
  localparam int unsigned Depth = FrontLat + 2;
  localparam int unsigned QW = 6 * TrigW;
  localparam int unsigned BackLat = 3;
  localparam int unsigned ODepth = BackLat + 2;

  logic f_vld, q_empty, q_pop, b_adv, b_vld;
  logic [$clog2(Depth+1)-1:0] q_cnt;
  trig_t f_sin [3], f_cos [3], b_sin [3], b_cos [3];
  logic [QW-1:0] q_in, q_out;
  logic signed [QUAT_WIDTH-1:0] b_q [4];
  logic [4*QUAT_WIDTH-1:0] o_in, o_out;
  logic o_empty;
  logic [$clog2(ODepth+1)-1:0] o_cnt;
  logic o_pop;

  // front always advances; admission is bounded by queue room
  assign in_if.ready = (32'(q_cnt) + FrontLat + 1) <= Depth;

  e2q_front #(.ANGLE_WIDTH(ANGLE_WIDTH), .TRIG_ITERATIONS(TRIG_ITERATIONS)) u_front (
    .clk_i, .rst_ni, .adv_i(1'b1),
    .in_valid_i(in_if.valid & in_if.ready),
    .roll_i(in_if.roll_angle), .pitch_i(in_if.pitch_angle), .yaw_i(in_if.yaw_angle),
    .out_valid_o(f_vld), .sin_o(f_sin), .cos_o(f_cos)
  );

  assign q_in = {f_sin[0], f_sin[1], f_sin[2], f_cos[0], f_cos[1], f_cos[2]};

  e2q_queue #(.WIDTH(QW), .DEPTH(Depth)) u_mid (
    .clk_i, .rst_ni, .push_i(f_vld), .data_i(q_in), .pop_i(q_pop),
    .data_o(q_out), .empty_o(q_empty), .count_o(q_cnt)
  );

  assign {b_sin[0], b_sin[1], b_sin[2], b_cos[0], b_cos[1], b_cos[2]} = q_out;

  // back advances while the output queue has room for its pipe
  assign b_adv = (32'(o_cnt) + BackLat + 1) <= ODepth;
  assign q_pop = b_adv & ~q_empty;

  e2q_back #(.QUAT_WIDTH(QUAT_WIDTH)) u_back (
    .clk_i, .rst_ni, .adv_i(b_adv), .in_valid_i(q_pop),
    .sin_i(b_sin), .cos_i(b_cos), .out_valid_o(b_vld), .quat_o(b_q)
  );

  assign o_in = {b_q[0], b_q[1], b_q[2], b_q[3]};
  assign o_pop = out_if.ready & ~o_empty;

  e2q_queue #(.WIDTH(4*QUAT_WIDTH), .DEPTH(ODepth)) u_out (
    .clk_i, .rst_ni, .push_i(b_vld & b_adv), .data_i(o_in), .pop_i(o_pop),
    .data_o(o_out), .empty_o(o_empty), .count_o(o_cnt)
  );

  assign out_if.valid = ~o_empty;
  assign {out_if.quat_w, out_if.quat_x, out_if.quat_y, out_if.quat_z} = o_out;
endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import e2q_pkg::*;

  localparam int unsigned AW = 16;
  localparam int unsigned QW = 16;
  localparam int unsigned NIT = 16;
  localparam int unsigned NRAND = 1450;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic signed [AW-1:0] HALF_TURN = 16'sd25736;

  typedef struct packed {
    logic signed [QW-1:0] w;
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
    logic                 typed;
    quat_t                q;
  } dir_row_t;

  localparam longint ATAN_Q30 [NIT] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF
  };
  localparam longint HALF_PI_Q30 = 64'h6487ED51;
  localparam longint GAIN_Q30 = 64'h26DD3B6A;

  localparam quat_t NONE = '0;
  localparam quat_t IDENT = '{w: 16'sd16384, x: 16'sd0, y: 16'sd0, z: 16'sd0};

  logic clk_i;
  logic rst_ni;

  e2q_angle_if #(.ANGLE_WIDTH(AW)) ang_if ();
  e2q_quat_if #(.QUAT_WIDTH(QW)) qt_if ();

  euler_to_quaternion_core #(
    .ANGLE_WIDTH(AW),
    .QUAT_WIDTH(QW),
    .TRIG_ITERATIONS(NIT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (ang_if.sink),
    .out_if(qt_if.source)
  );

  quat_t quat_due_q[$];
  quat_t typed_q[$];
  bit    typed_flag_q[$];
  int    n_sent;
  int    n_checked;
  int    n_bad;
  bit    always_ready;
  bit    hold_req;
  int    hold_cnt;
  int    stall_cnt;

  dir_row_t dir_tab [14] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, IDENT},
    '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, NONE},
    '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b0, NONE},
    '{16'sh7FFF, 16'sd0, 16'sd0, 1'b0, NONE},
    '{16'sd0, -16'sh8000, 16'sd0, 1'b0, NONE},
    '{16'sd0, 16'sd0, 16'sh7FFF, 1'b0, NONE},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0, NONE},
    '{16'sd1, 16'sd1, 16'sd1, 1'b0, NONE},
    '{HALF_TURN, 16'sd0, 16'sd0, 1'b0, NONE},
    '{-HALF_TURN, HALF_TURN, 16'sd0, 1'b0, NONE},
    '{16'sd12868, -16'sd12868, 16'sd12868, 1'b0, NONE},
    '{16'sd25737, -16'sd25737, 16'sd25735, 1'b0, NONE},
    '{16'sh5555, -16'sh2AAB, 16'sh1234, 1'b0, NONE},
    '{-16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, NONE}
  };

  function automatic void half_sin_cos(input logic signed [AW-1:0] raw,
                                       output longint c, output longint s);
    longint a, x, y, z, dx, dy;
    bit flip;
    a = longint'(raw) <<< (32 - AW);
    flip = 1'b0;
    if (a > HALF_PI_Q30) begin
      a = 2 * HALF_PI_Q30 - a;
      flip = 1'b1;
    end else if (a < -HALF_PI_Q30) begin
      a = -2 * HALF_PI_Q30 - a;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    z = a;
    for (int i = 0; i < NIT; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q30[i];
      end
    end
    c = flip ? -x : x;
    s = y;
  endfunction

  function automatic longint triple(longint yf, longint rf, longint pf);
    return ((yf * rf) >>> 30) * pf;
  endfunction

  function automatic logic signed [QW-1:0] round_q14(longint acc);
    longint r;
    longint one;
    one = longint'(1) <<< (QW - 2);
    r = (acc + (longint'(1) <<< (60 - QW + 1))) >>> (60 - QW + 2);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return r[QW-1:0];
  endfunction

  function automatic quat_t zyx_to_quat(logic signed [AW-1:0] roll,
                                        logic signed [AW-1:0] pitch,
                                        logic signed [AW-1:0] yaw);
    longint cr, sr, cp, sp, cy, sy;
    quat_t q;
    half_sin_cos(roll, cr, sr);
    half_sin_cos(pitch, cp, sp);
    half_sin_cos(yaw, cy, sy);
    q.w = round_q14(triple(cy, cr, cp) + triple(sy, sr, sp));
    q.x = round_q14(triple(cy, sr, cp) - triple(sy, cr, sp));
    q.y = round_q14(triple(cy, cr, sp) + triple(sy, sr, cp));
    q.z = round_q14(triple(sy, cr, cp) - triple(cy, sr, sp));
    return q;
  endfunction

  task automatic report_bad(string msg);
    $display("MISMATCH beat %0d: %s", n_checked, msg);
    n_bad++;
  endtask

  function automatic logic signed [AW-1:0] pick_angle();
    logic signed [AW-1:0] corner [8] = '{16'sh7FFF, -16'sh8000, 16'sd0, -16'sd1,
                                         HALF_TURN, -HALF_TURN, 16'sd12868, -16'sd12868};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 7)];
    return AW'($urandom());
  endfunction

  task automatic send(logic signed [AW-1:0] roll, logic signed [AW-1:0] pitch,
                      logic signed [AW-1:0] yaw, bit typed, quat_t q, bit gaps);
    int gap;
    typed_flag_q = {typed_flag_q, typed};
    typed_q = {typed_q, q};
    ang_if.valid <= 1'b1;
    ang_if.roll_angle <= roll;
    ang_if.pitch_angle <= pitch;
    ang_if.yaw_angle <= yaw;
    do @(posedge clk_i); while (!ang_if.ready);
    gap = 0;
    if (gaps) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
        5: gap = $urandom_range(10, 40);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      ang_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout waiting for quaternion beats");
    $display("** euler_to_quaternion_core: FAILED **");
    $finish;
  end

  // predict on every accepted angle beat
  always @(posedge clk_i) begin
    quat_t q;
    bit typed;
    if (rst_ni && ang_if.valid && ang_if.ready) begin
      q = zyx_to_quat(ang_if.roll_angle, ang_if.pitch_angle, ang_if.yaw_angle);
      typed = typed_flag_q.pop_front();
      if (typed && q != typed_q[0]) begin
        report_bad($sformatf("predictor disagrees with table row %0d", n_sent));
      end
      void'(typed_q.pop_front());
      quat_due_q = {quat_due_q, q};
      n_sent++;
    end
  end

  // check results and drive ready
  always @(posedge clk_i) begin
    quat_t want;
    if (rst_ni) begin
      if (qt_if.valid && qt_if.ready) begin
        if (quat_due_q.size() == 0) begin
          report_bad("unexpected quaternion beat");
        end else begin
          want = quat_due_q.pop_front();
          if (qt_if.quat_w !== want.w)
            report_bad($sformatf("w got %0d want %0d", qt_if.quat_w, want.w));
          if (qt_if.quat_x !== want.x)
            report_bad($sformatf("x got %0d want %0d", qt_if.quat_x, want.x));
          if (qt_if.quat_y !== want.y)
            report_bad($sformatf("y got %0d want %0d", qt_if.quat_y, want.y));
          if (qt_if.quat_z !== want.z)
            report_bad($sformatf("z got %0d want %0d", qt_if.quat_z, want.z));
          n_checked++;
        end
      end
      if (hold_req && hold_cnt == 0) hold_cnt = LONG_HOLD;
      if (hold_cnt > 0) begin
        hold_cnt--;
        qt_if.ready <= 1'b0;
      end else if (always_ready) begin
        qt_if.ready <= 1'b1;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        qt_if.ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3: stall_cnt = $urandom_range(0, 2);
          4: stall_cnt = $urandom_range(15, 50);
          default: stall_cnt = 0;
        endcase
        qt_if.ready <= (stall_cnt == 0);
      end
    end
  end

  initial begin
    n_sent = 0;
    n_checked = 0;
    n_bad = 0;
    always_ready = 1'b1;
    hold_req = 1'b0;
    hold_cnt = 0;
    stall_cnt = 0;
    ang_if.valid = 1'b0;
    ang_if.roll_angle = '0;
    ang_if.pitch_angle = '0;
    ang_if.yaw_angle = '0;
    qt_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      send(dir_tab[i].roll, dir_tab[i].pitch, dir_tab[i].yaw, dir_tab[i].typed,
           dir_tab[i].q, 1'b0);
    ang_if.valid <= 1'b0;
    while (quat_due_q.size() != 0) @(posedge clk_i);

    // back-to-back with a long receiver hold to fill the pipe
    hold_req = 1'b1;
    for (int i = 0; i < 100; i++) begin
      if (i == 2) hold_req = 1'b0;
      send(pick_angle(), pick_angle(), pick_angle(), 1'b0, NONE, 1'b0);
    end
    ang_if.valid <= 1'b0;
    while (quat_due_q.size() != 0) @(posedge clk_i);

    always_ready = 1'b0;
    for (int i = 0; i < NRAND - 100; i++) begin
      send(pick_angle(), pick_angle(), pick_angle(), 1'b0, NONE, 1'b1);
      if (i % 400 == 399) begin
        ang_if.valid <= 1'b0;
        while (quat_due_q.size() != 0) @(posedge clk_i);
      end
    end
    ang_if.valid <= 1'b0;

    while (quat_due_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("sent %0d angle beats (corners, quadrant folds, random), checked %0d quaternions",
             n_sent, n_checked);
    $display("with random gaps, receiver stalls and one long back-pressure hold");
    if (n_bad == 0) begin
      $display("** euler_to_quaternion_core: PASSED **");
    end else begin
      $display("** euler_to_quaternion_core: FAILED **");
    end
    $finish;
  end

endmodule
